[sv/rtcm3_frame_receiver_macros.svh]
// assertion macros for the rtcm3 frame receiver
`ifndef RTCM3_FRAME_RECEIVER_MACROS_SVH
`define RTCM3_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define RTCM3FR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcm3fr same-cycle check failed");

// next-cycle implication, checked outside reset
`define RTCM3FR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcm3fr next-cycle check failed");

`else

`define RTCM3FR_ASSERT_NOW(label, ante, cons)
`define RTCM3FR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/rtcm3fr_pkg.sv]
// types, constants and the crc-24q byte update for the rtcm3 frame receiver
`default_nettype none

package rtcm3fr_pkg;

    // frame constants
    localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
    localparam logic [23:0] CRC24Q_POLY   = 24'h864CFB;

    // register map
    localparam logic REG_MAX_FRAME = 1'b0;
    localparam logic REG_JUMBO     = 1'b1;

    // register reset values
    localparam logic [10:0] MAX_FRAME_RESET = 11'd1029;
    localparam logic [10:0] JUMBO_RESET     = 11'd250;

    // header plus crc overhead
    localparam logic [10:0] FRAME_OVERHEAD = 11'd6;
    localparam logic [10:0] PAYLOAD_END    = 11'd3;
    localparam logic [10:0] CRC_LAST_POS   = 11'd5;

    // width of the counter fields in the result item
    localparam int CNT_FIELD_W = 32;

    // event codes
    localparam logic [3:0] EV_DROP     = 4'd0;
    localparam logic [3:0] EV_PREAMBLE = 4'd1;
    localparam logic [3:0] EV_LENGTH   = 4'd2;
    localparam logic [3:0] EV_PAYLOAD  = 4'd3;
    localparam logic [3:0] EV_CRC_BYTE = 4'd4;
    localparam logic [3:0] EV_FRAME_OK = 4'd5;
    localparam logic [3:0] EV_CRC_ERR  = 4'd6;
    localparam logic [3:0] EV_TOO_LONG = 4'd7;
    localparam logic [3:0] EV_ZERO_LEN = 4'd8;

    // receive phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } phase_t;

    // result item, last-declared field (data_out) in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [6:0]             pad;
        logic [CNT_FIELD_W-1:0] jumbo_frame_count;
        logic [CNT_FIELD_W-1:0] length_error_count;
        logic [CNT_FIELD_W-1:0] crc_error_count;
        logic [CNT_FIELD_W-1:0] good_byte_count;
        logic [CNT_FIELD_W-1:0] good_frame_count;
        logic [9:0]             payload_length;
        logic [3:0]             event_res;
        logic [10:0]            byte_index;
        logic [7:0]             data_out;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // one byte of crc-24q, msb first, not reflected
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                                input logic [7:0]  byte_in);
        logic [23:0] c;
        c = crc_in ^ {byte_in, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            if (c[23])
                c = {c[22:0], 1'b0} ^ CRC24Q_POLY;
            else
                c = {c[22:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/rtcm3_frame_receiver.sv]
// rtcm3 framing receiver: preamble hunt, length check, crc-24q check, statistics
//
// Input channel s_axis carries one received byte per item in tdata[7:0].
// Output channel m_axis returns one result item for every input item: the
// byte echoed, its index in the frame, an event code, the header payload
// length and the five statistics counters after that byte.
// Configuration: cfg_we with cfg_index 0 writes max_frame_bytes, index 1
// writes jumbo_threshold; write only while no item is in flight.
// Each accepted item's result is registered, in the result register or, while
// the output is stalled, in the skid register. Throughput is one item per cycle
// while s_axis_tready is high: the crc-24q byte update, the length compares and
// the counter adds all sit between the state registers and the result register.
// A two-entry output stage (result register plus skid register) lets the
// block take a new item while a result is still waiting; s_axis_tready drops
// only once both entries are full, and rises again as soon as the receiver
// takes an item.
// Reset puts the block in the hunt phase, clears all counters and loads the
// register defaults (max_frame_bytes 1029, jumbo_threshold 250).
// Counters wrap at COUNTER_BITS bits and are reported zero-extended.
`default_nettype none

`include "rtcm3_frame_receiver_macros.svh"

module rtcm3_frame_receiver #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [10:0]                      cfg_data,
    // received bytes
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,   // data_in
    // result items
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // data_out, byte_index, event_res, payload_length, good_frame_count,
    // good_byte_count, crc_error_count, length_error_count, jumbo_frame_count, pad
    output      logic [rtcm3fr_pkg::RESULT_W-1:0] m_axis_tdata
);

    import rtcm3fr_pkg::*;

    // configuration registers
    logic [10:0] max_frame_reg;
    logic [10:0] jumbo_thr_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [10:0] pos_reg, pos_next;
    logic [9:0]  len_reg, len_next;
    logic [23:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    // statistics counters
    logic [COUNTER_BITS-1:0] good_frames_reg, good_frames_next;
    logic [COUNTER_BITS-1:0] good_bytes_reg, good_bytes_next;
    logic [COUNTER_BITS-1:0] crc_bad_reg, crc_bad_next;
    logic [COUNTER_BITS-1:0] too_long_reg, too_long_next;
    logic [COUNTER_BITS-1:0] jumbo_reg, jumbo_next;

    // output stage
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    // per-item working values
    logic        s_accept;
    logic [7:0]  rx_byte;
    logic [10:0] idx;
    logic [3:0]  ev;
    logic        finish;
    logic [10:0] frame_total;
    logic [10:0] crc_total;
    logic [23:0] rx_full;
    logic [9:0]  plen;

    assign s_axis_tready = !skid_valid_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign rx_byte       = s_axis_tdata;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
            jumbo_thr_reg <= JUMBO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_FRAME: max_frame_reg <= cfg_data;
                REG_JUMBO:     jumbo_thr_reg <= cfg_data;
                default:       max_frame_reg <= max_frame_reg;
            endcase
        end
    end

    // frame parser and counter update for one byte
    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        len_next         = len_reg;
        crc_next         = crc_reg;
        rx_crc_next      = rx_crc_reg;
        good_frames_next = good_frames_reg;
        good_bytes_next  = good_bytes_reg;
        crc_bad_next     = crc_bad_reg;
        too_long_next    = too_long_reg;
        jumbo_next       = jumbo_reg;
        idx              = 11'd0;
        ev               = EV_DROP;
        finish           = 1'b0;
        frame_total      = {1'b0, len_reg} + FRAME_OVERHEAD;
        crc_total        = {1'b0, len_reg} + CRC_LAST_POS;
        rx_full          = {rx_crc_reg, rx_byte};

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == RTCM_PREAMBLE)
                begin
                    crc_next   = crc24q_byte(24'h000000, rx_byte);
                    pos_next   = 11'd1;
                    phase_next = PH_LEN;
                    ev         = EV_PREAMBLE;
                end
            end
            PH_LEN:
            begin
                idx      = pos_reg;
                crc_next = crc24q_byte(crc_reg, rx_byte);
                ev       = EV_LENGTH;
                if (pos_reg == 11'd1)
                begin
                    len_next = {rx_byte[1:0], 8'h00};
                    pos_next = 11'd2;
                end
                else
                begin
                    len_next    = {len_reg[9:8], rx_byte};
                    pos_next    = 11'd3;
                    frame_total = {1'b0, len_next} + FRAME_OVERHEAD;
                    if (frame_total > max_frame_reg)
                    begin
                        too_long_next = too_long_reg + COUNTER_BITS'(1);
                        ev            = EV_TOO_LONG;
                        finish        = 1'b1;
                    end
                    else if (len_next == 10'd0)
                    begin
                        ev     = EV_ZERO_LEN;
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                idx      = pos_reg;
                crc_next = crc24q_byte(crc_reg, rx_byte);
                ev       = EV_PAYLOAD;
                pos_next = pos_reg + 11'd1;
                if (pos_next >= ({1'b0, len_reg} + PAYLOAD_END))
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                idx = pos_reg;
                if (pos_reg < crc_total)
                begin
                    rx_crc_next = {rx_crc_reg[7:0], rx_byte};
                    pos_next    = pos_reg + 11'd1;
                    ev          = EV_CRC_BYTE;
                end
                else
                begin
                    if (rx_full == crc_reg)
                    begin
                        good_frames_next = good_frames_reg + COUNTER_BITS'(1);
                        good_bytes_next  = good_bytes_reg + COUNTER_BITS'(frame_total);
                        if (frame_total > jumbo_thr_reg)
                            jumbo_next = jumbo_reg + COUNTER_BITS'(1);
                        ev = EV_FRAME_OK;
                    end
                    else
                    begin
                        crc_bad_next = crc_bad_reg + COUNTER_BITS'(1);
                        ev           = EV_CRC_ERR;
                    end
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // header length is reported once known, including on the closing byte
        if (phase_next == PH_PAYLOAD || phase_next == PH_CRC || finish)
            plen = len_next;
        else
            plen = 10'd0;

        // frame ended or aborted: back to hunting
        if (finish)
        begin
            phase_next  = PH_HUNT;
            pos_next    = 11'd0;
            len_next    = 10'd0;
            crc_next    = 24'h000000;
            rx_crc_next = 16'h0000;
        end

        res_next.pad                = '0;
        res_next.data_out           = rx_byte;
        res_next.byte_index         = idx;
        res_next.event_res          = ev;
        res_next.payload_length     = plen;
        res_next.good_frame_count   = CNT_FIELD_W'(good_frames_next);
        res_next.good_byte_count    = CNT_FIELD_W'(good_bytes_next);
        res_next.crc_error_count    = CNT_FIELD_W'(crc_bad_next);
        res_next.length_error_count = CNT_FIELD_W'(too_long_next);
        res_next.jumbo_frame_count  = CNT_FIELD_W'(jumbo_next);
    end

    // frame state and counters advance on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            pos_reg         <= 11'd0;
            len_reg         <= 10'd0;
            crc_reg         <= 24'h000000;
            rx_crc_reg      <= 16'h0000;
            good_frames_reg <= '0;
            good_bytes_reg  <= '0;
            crc_bad_reg     <= '0;
            too_long_reg    <= '0;
            jumbo_reg       <= '0;
        end
        else if (s_accept)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            len_reg         <= len_next;
            crc_reg         <= crc_next;
            rx_crc_reg      <= rx_crc_next;
            good_frames_reg <= good_frames_next;
            good_bytes_reg  <= good_bytes_next;
            crc_bad_reg     <= crc_bad_next;
            too_long_reg    <= too_long_next;
            jumbo_reg       <= jumbo_next;
        end
    end

    // output valid flags: result register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= s_accept;
            end
        end
        else if (s_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (s_accept)
                out_reg <= res_next;
        end
        else if (s_accept)
        begin
            skid_reg <= res_next;
        end
    end

    // checks
    `RTCM3FR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `RTCM3FR_ASSERT_NEXT(a_skid_keeps_out, skid_valid_reg, out_valid_reg)
    `RTCM3FR_ASSERT_NOW(a_hunt_is_clean, phase_reg == PH_HUNT,
        pos_reg == 11'd0 && len_reg == 10'd0 && rx_crc_reg == 16'h0000)
    `RTCM3FR_ASSERT_NEXT(a_counters_idle, !s_accept,
        $stable(good_frames_reg) && $stable(crc_bad_reg) && $stable(too_long_reg))

endmodule

`default_nettype wire
